>>> rtl/rfwc_pkg.sv
package rfwc_pkg;

    localparam int unsigned DIM_W   = 12;
    localparam int unsigned PITCH_W = 16;
    localparam int unsigned TICK_W  = 24;
    localparam int unsigned ADDR_W  = 28;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // Arm length of the crosshair in pixels on each side of the centre.
    localparam logic [DIM_W:0] CROSS_ARM = 13'd20;

    localparam logic [WORD_W-1:0] GREEN565      = 16'h07E0;
    localparam logic [ADDR_W-1:0] NO_WRITE_ADDR = 28'hFFFFFFF;

    localparam logic [DIM_W-1:0]   RST_DISPLAY_WIDTH  = 12'd1280;
    localparam logic [DIM_W-1:0]   RST_DISPLAY_HEIGHT = 12'd720;
    localparam logic [PITCH_W-1:0] RST_PITCH_BYTES    = 16'd2560;
    localparam logic [TICK_W-1:0]  RST_FRAME_INTERVAL = 24'd16667;

    // Input request kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] RES_WRITE    = 2'd0;
    localparam logic [KIND_W-1:0] RES_ACCEPTED = 2'd1;
    localparam logic [KIND_W-1:0] RES_SKIPPED  = 2'd2;
    localparam logic [KIND_W-1:0] RES_COMPLETE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_BYTES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd3;

    // What the pixel mapper tells the control about the current source pixel.
    typedef struct packed {
        logic              in_crop;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } t_pix_info;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  presented;
        logic [CNT_W-1:0]  skipped;
    } t_result;

endpackage

>>> rtl/rfwc_pix_map.sv
module rfwc_pix_map (
    input  logic [rfwc_pkg::DIM_W-1:0]   i_col,
    input  logic [rfwc_pkg::DIM_W-1:0]   i_row,
    input  logic [rfwc_pkg::DIM_W-1:0]   i_src_width,
    input  logic [rfwc_pkg::DIM_W-1:0]   i_src_height,
    input  logic [rfwc_pkg::DIM_W-1:0]   i_disp_width,
    input  logic [rfwc_pkg::DIM_W-1:0]   i_disp_height,
    input  logic [rfwc_pkg::ADDR_W-1:0]  i_row_base,
    input  logic [rfwc_pkg::COLOR_W-1:0] i_red,
    input  logic [rfwc_pkg::COLOR_W-1:0] i_green,
    input  logic [rfwc_pkg::COLOR_W-1:0] i_blue,
    output rfwc_pkg::t_pix_info          o_info
);
    import rfwc_pkg::*;

    logic [DIM_W-1:0]  crop_w;
    logic [DIM_W-1:0]  crop_h;
    logic [DIM_W:0]    col_x;
    logic [DIM_W:0]    row_x;
    logic [DIM_W:0]    cx;
    logic [DIM_W:0]    cy;
    logic              horiz;
    logic              vert;
    logic              in_crop;
    logic [WORD_W-1:0] rgb565;

    always_comb begin
        crop_w  = (i_src_width < i_disp_width) ? i_src_width : i_disp_width;
        crop_h  = (i_src_height < i_disp_height) ? i_src_height : i_disp_height;
        in_crop = (i_col < crop_w) && (i_row < crop_h);

        // Widen by one bit so that the arm offsets cannot wrap.
        col_x = {1'b0, i_col};
        row_x = {1'b0, i_row};
        cx    = {2'b00, i_disp_width[DIM_W-1:1]};
        cy    = {2'b00, i_disp_height[DIM_W-1:1]};
        horiz = (row_x == cy) && (col_x + CROSS_ARM >= cx) && (col_x <= cx + CROSS_ARM);
        vert  = (col_x == cx) && (row_x + CROSS_ARM >= cy) && (row_x <= cy + CROSS_ARM);

        rgb565 = {i_red[7:3], i_green[7:2], i_blue[7:3]};

        o_info.in_crop = in_crop;
        o_info.last    = (col_x + 13'd1 >= {1'b0, i_src_width})
                      && (row_x + 13'd1 >= {1'b0, i_src_height});
        o_info.addr    = i_row_base + {{(ADDR_W-DIM_W-1){1'b0}}, i_col, 1'b0};
        if (!in_crop) begin
            o_info.word = '0;
        end else if (horiz || vert) begin
            o_info.word = GREEN565;
        end else begin
            o_info.word = rgb565;
        end
    end

endmodule

>>> rtl/rgb565_frame_writer_with_crosshair_top.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_kind, i_frame_width, i_frame_height,
//                                           i_red, i_green, i_blue
// result    out        o_valid / i_ready    o_result_kind, o_write_address,
//                                           o_pixel_word, o_presented_count,
//                                           o_skipped_count
// config    in         i_cfg_wr_en          i_cfg_index, i_cfg_wdata
//
// One request is taken per clock while o_ready is high; its result is registered at the
// accepting edge (in the skid register if the output is stalled), as is all frame state.
// A two-entry output buffer (output register plus skid register) keeps o_ready high
// while one result waits; o_ready drops only when both entries are full.
// Synchronous active-low reset restores register defaults and clears frame and valid state.
module rgb565_frame_writer_with_crosshair_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rfwc_pkg::KIND_W-1:0]    i_kind,
    input  logic [rfwc_pkg::DIM_W-1:0]     i_frame_width,
    input  logic [rfwc_pkg::DIM_W-1:0]     i_frame_height,
    input  logic [rfwc_pkg::COLOR_W-1:0]   i_red,
    input  logic [rfwc_pkg::COLOR_W-1:0]   i_green,
    input  logic [rfwc_pkg::COLOR_W-1:0]   i_blue,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rfwc_pkg::KIND_W-1:0]    o_result_kind,
    output logic [rfwc_pkg::ADDR_W-1:0]    o_write_address,
    output logic [rfwc_pkg::WORD_W-1:0]    o_pixel_word,
    output logic [rfwc_pkg::CNT_W-1:0]     o_presented_count,
    output logic [rfwc_pkg::CNT_W-1:0]     o_skipped_count,
    input  logic                           i_cfg_wr_en,
    input  logic [rfwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfwc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import rfwc_pkg::*;

    logic [DIM_W-1:0]   r_disp_width;
    logic [DIM_W-1:0]   r_disp_height;
    logic [PITCH_W-1:0] r_pitch;
    logic [TICK_W-1:0]  r_interval;

    logic [TICK_W-1:0]  r_elapsed, n_elapsed;
    logic               r_active, n_active;
    logic [DIM_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_row, n_row;
    logic [DIM_W-1:0]   r_src_width, n_src_width;
    logic [DIM_W-1:0]   r_src_height, n_src_height;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [CNT_W-1:0]   r_presented, n_presented;
    logic [CNT_W-1:0]   r_skipped, n_skipped;

    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               accept;
    logic               have_res;
    t_result            res;
    t_pix_info          pix;
    logic [DIM_W-1:0]   col_inc;

    rfwc_pix_map u_pix_map (
        .i_col         (r_col),
        .i_row         (r_row),
        .i_src_width   (r_src_width),
        .i_src_height  (r_src_height),
        .i_disp_width  (r_disp_width),
        .i_disp_height (r_disp_height),
        .i_row_base    (r_row_base),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_info        (pix)
    );

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_elapsed    = r_elapsed;
        n_active     = r_active;
        n_col        = r_col;
        n_row        = r_row;
        n_src_width  = r_src_width;
        n_src_height = r_src_height;
        n_row_base   = r_row_base;
        n_presented  = r_presented;
        n_skipped    = r_skipped;
        have_res     = 1'b0;
        res.kind     = RES_WRITE;
        res.addr     = '0;
        res.word     = '0;
        col_inc      = r_col + 12'd1;

        if (accept) begin
            case (i_kind)
                KIND_TICK: begin
                    if (r_elapsed != {TICK_W{1'b1}}) begin
                        n_elapsed = r_elapsed + 24'd1;
                    end
                end
                KIND_START: begin
                    have_res = 1'b1;
                    if (r_elapsed >= r_interval) begin
                        n_src_width  = i_frame_width;
                        n_src_height = i_frame_height;
                        n_col        = '0;
                        n_row        = '0;
                        n_row_base   = '0;
                        n_active     = (i_frame_width != '0) && (i_frame_height != '0);
                        n_elapsed    = '0;
                        n_presented  = r_presented + 32'd1;
                        res.kind     = RES_ACCEPTED;
                    end else begin
                        n_active  = 1'b0;
                        n_skipped = r_skipped + 32'd1;
                        res.kind  = RES_SKIPPED;
                    end
                end
                KIND_PIXEL: begin
                    if (r_active) begin
                        if (col_inc >= r_src_width) begin
                            n_col      = '0;
                            n_row      = r_row + 12'd1;
                            n_row_base = r_row_base + {{(ADDR_W-PITCH_W){1'b0}}, r_pitch};
                        end else begin
                            n_col = col_inc;
                        end
                        res.addr = pix.addr;
                        res.word = pix.word;
                        if (pix.last) begin
                            n_active = 1'b0;
                            have_res = 1'b1;
                            res.kind = RES_COMPLETE;
                            if (!pix.in_crop) begin
                                res.addr = NO_WRITE_ADDR;
                            end
                        end else begin
                            have_res = pix.in_crop;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res.presented = n_presented;
        res.skipped   = n_skipped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_width  <= RST_DISPLAY_WIDTH;
            r_disp_height <= RST_DISPLAY_HEIGHT;
            r_pitch       <= RST_PITCH_BYTES;
            r_interval    <= RST_FRAME_INTERVAL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DISPLAY_WIDTH:  r_disp_width  <= i_cfg_wdata[DIM_W-1:0];
                CFG_DISPLAY_HEIGHT: r_disp_height <= i_cfg_wdata[DIM_W-1:0];
                CFG_PITCH_BYTES:    r_pitch       <= i_cfg_wdata[PITCH_W-1:0];
                CFG_FRAME_INTERVAL: r_interval    <= i_cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_active     <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_src_width  <= '0;
            r_src_height <= '0;
            r_row_base   <= '0;
            r_presented  <= '0;
            r_skipped    <= '0;
        end else begin
            r_elapsed    <= n_elapsed;
            r_active     <= n_active;
            r_col        <= n_col;
            r_row        <= n_row;
            r_src_width  <= n_src_width;
            r_src_height <= n_src_height;
            r_row_base   <= n_row_base;
            r_presented  <= n_presented;
            r_skipped    <= n_skipped;
        end
    end

    // The skid register only fills while the output register is stalled, and it
    // drains into the output register before any new result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= have_res;
            end
        end else if (have_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (have_res) begin
                r_out <= res;
            end
        end else if (have_res) begin
            r_skid <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out.kind;
    assign o_write_address   = r_out.addr;
    assign o_pixel_word      = r_out.word;
    assign o_presented_count = r_out.presented;
    assign o_skipped_count   = r_out.skipped;

endmodule

>>> tb/rfwc_monitor.sv
`timescale 1ns / 100ps

module rfwc_monitor
    import rfwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [DIM_W-1:0]      i_frame_width,
    input  logic [DIM_W-1:0]      i_frame_height,
    input  logic [COLOR_W-1:0]    i_red,
    input  logic [COLOR_W-1:0]    i_green,
    input  logic [COLOR_W-1:0]    i_blue,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [KIND_W-1:0]     i_res_kind,
    input  logic [ADDR_W-1:0]     i_res_address,
    input  logic [WORD_W-1:0]     i_res_word,
    input  logic [CNT_W-1:0]      i_res_presented,
    input  logic [CNT_W-1:0]      i_res_skipped,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    logic [DIM_W-1:0]   disp_w;
    logic [DIM_W-1:0]   disp_h;
    logic [PITCH_W-1:0] pitch;
    logic [TICK_W-1:0]  interval;

    logic [TICK_W-1:0]  ticks_since;
    logic               in_frame;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
    logic [ADDR_W-1:0]  row_base;
    logic [CNT_W-1:0]   n_presented;
    logic [CNT_W-1:0]   n_skipped;

    t_result writes_due[$];

    // The arms are tested by distance from the centre, so a centre near an edge
    // still gives full-length arms in the arithmetic.
    function automatic logic on_crosshair(input int unsigned c, input int unsigned r);
        int unsigned cx;
        int unsigned cy;
        cx = 32'(disp_w) / 2;
        cy = 32'(disp_h) / 2;
        return ((r == cy) && (c + CROSS_ARM >= cx) && (c <= cx + CROSS_ARM)) ||
               ((c == cx) && (r + CROSS_ARM >= cy) && (r <= cy + CROSS_ARM));
    endfunction

    task automatic note_result(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                               input logic [WORD_W-1:0] w);
        t_result res;
        res.kind      = k;
        res.addr      = a;
        res.word      = w;
        res.presented = n_presented;
        res.skipped   = n_skipped;
        writes_due.push_back(res);
    endtask

    task automatic advance_frame_writer(input logic [KIND_W-1:0] kind,
                                        input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh,
                                        input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                        input logic [COLOR_W-1:0] b);
        int unsigned       c;
        int unsigned       rw;
        int unsigned       cw;
        int unsigned       ch;
        logic              in_crop;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [DIM_W-1:0]  next_col;
        case (kind)
            KIND_TICK: begin
                if (ticks_since != {TICK_W{1'b1}})
                    ticks_since = ticks_since + 24'd1;
            end
            KIND_START: begin
                if (ticks_since >= interval) begin
                    src_w       = fw;
                    src_h       = fh;
                    col         = '0;
                    row         = '0;
                    row_base    = '0;
                    in_frame    = (fw != 0) && (fh != 0);
                    ticks_since = '0;
                    n_presented = n_presented + 32'd1;
                    note_result(RES_ACCEPTED, '0, '0);
                end else begin
                    in_frame  = 1'b0;
                    n_skipped = n_skipped + 32'd1;
                    note_result(RES_SKIPPED, '0, '0);
                end
            end
            KIND_PIXEL: begin
                if (in_frame) begin
                    c       = 32'(col);
                    rw      = 32'(row);
                    cw      = (src_w < disp_w) ? 32'(src_w) : 32'(disp_w);
                    ch      = (src_h < disp_h) ? 32'(src_h) : 32'(disp_h);
                    in_crop = (c < cw) && (rw < ch);
                    last    = (c + 1 >= 32'(src_w)) && (rw + 1 >= 32'(src_h));
                    addr    = row_base + ADDR_W'(c * 2);
                    word    = '0;
                    if (in_crop)
                        word = on_crosshair(c, rw) ? GREEN565
                             : {r[7:3], g[7:2], b[7:3]};
                    next_col = col + 12'd1;
                    if (next_col >= src_w) begin
                        col      = '0;
                        row      = row + 12'd1;
                        row_base = row_base + ADDR_W'(pitch);
                    end else begin
                        col = next_col;
                    end
                    if (last) begin
                        in_frame = 1'b0;
                        if (in_crop)
                            note_result(RES_COMPLETE, addr, word);
                        else
                            note_result(RES_COMPLETE, NO_WRITE_ADDR, '0);
                    end else if (in_crop) begin
                        note_result(RES_WRITE, addr, word);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag(input string field, input logic [CNT_W-1:0] want,
                        input logic [CNT_W-1:0] got);
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        o_mismatches = o_mismatches + 1;
    endtask

    task automatic compare_result();
        t_result due;
        if (writes_due.size() == 0) begin
            $display("%0t: unexpected result kind %0d address %h word %h", $time,
                     i_res_kind, i_res_address, i_res_word);
            o_mismatches = o_mismatches + 1;
        end else begin
            due = writes_due.pop_front();
            if (i_res_kind !== due.kind)
                flag("result kind", CNT_W'(due.kind), CNT_W'(i_res_kind));
            if (i_res_address !== due.addr)
                flag("write address", CNT_W'(due.addr), CNT_W'(i_res_address));
            if (i_res_word !== due.word)
                flag("pixel word", CNT_W'(due.word), CNT_W'(i_res_word));
            if (i_res_presented !== due.presented)
                flag("presented count", due.presented, i_res_presented);
            if (i_res_skipped !== due.skipped)
                flag("skipped count", due.skipped, i_res_skipped);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            disp_w       = RST_DISPLAY_WIDTH;
            disp_h       = RST_DISPLAY_HEIGHT;
            pitch        = RST_PITCH_BYTES;
            interval     = RST_FRAME_INTERVAL;
            ticks_since  = '0;
            in_frame     = 1'b0;
            col          = '0;
            row          = '0;
            src_w        = '0;
            src_h        = '0;
            row_base     = '0;
            n_presented  = '0;
            n_skipped    = '0;
            o_mismatches = 0;
            writes_due.delete();
        end else begin
            // A result leaves only after the edge that takes its request, so the oldest entry is
            // compared before this edge's request adds to the queue.
            if (i_res_valid && i_res_ready)
                compare_result();
            if (i_in_valid && i_in_ready)
                advance_frame_writer(i_kind, i_frame_width, i_frame_height,
                                     i_red, i_green, i_blue);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DISPLAY_WIDTH:  disp_w   = i_cfg_wdata[DIM_W-1:0];
                    CFG_DISPLAY_HEIGHT: disp_h   = i_cfg_wdata[DIM_W-1:0];
                    CFG_PITCH_BYTES:    pitch    = i_cfg_wdata[PITCH_W-1:0];
                    CFG_FRAME_INTERVAL: interval = i_cfg_wdata[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = writes_due.size();
    end

endmodule

>>> tb/tb_rgb565_frame_writer_with_crosshair_top.sv
`timescale 1ns / 100ps

module tb_rgb565_frame_writer_with_crosshair_top;
    import rfwc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int TOTAL_REQUESTS = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STEADY_FROM    = 1200;
    localparam int STEADY_TO      = 1800;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [KIND_W-1:0]     in_kind = KIND_TICK;
    logic [DIM_W-1:0]      in_width = '0;
    logic [DIM_W-1:0]      in_height = '0;
    logic [COLOR_W-1:0]    in_red = '0;
    logic [COLOR_W-1:0]    in_green = '0;
    logic [COLOR_W-1:0]    in_blue = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b1;
    logic [KIND_W-1:0]     res_kind;
    logic [ADDR_W-1:0]     res_address;
    logic [WORD_W-1:0]     res_word;
    logic [CNT_W-1:0]      res_presented;
    logic [CNT_W-1:0]      res_skipped;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DISPLAY_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          requests_sent = 0;
    int unsigned interval_now = 32'(RST_FRAME_INTERVAL);
    int unsigned cycle_no = 0;
    int unsigned idle_cycles = 0;

    rgb565_frame_writer_with_crosshair_top uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_kind            (in_kind),
        .i_frame_width     (in_width),
        .i_frame_height    (in_height),
        .i_red             (in_red),
        .i_green           (in_green),
        .i_blue            (in_blue),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_result_kind     (res_kind),
        .o_write_address   (res_address),
        .o_pixel_word      (res_word),
        .o_presented_count (res_presented),
        .o_skipped_count   (res_skipped),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata)
    );

    rfwc_monitor monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_frame_width   (in_width),
        .i_frame_height  (in_height),
        .i_red           (in_red),
        .i_green         (in_green),
        .i_blue          (in_blue),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_res_kind      (res_kind),
        .i_res_address   (res_address),
        .i_res_word      (res_word),
        .i_res_presented (res_presented),
        .i_res_skipped   (res_skipped),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic in_steady_window();
        return (cycle_no >= STEADY_FROM) && (cycle_no < STEADY_TO);
    endfunction

    always @(negedge clk) begin
        res_ready <= in_steady_window() || ($urandom_range(99) >= 9);
    end

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_rgb565_frame_writer_with_crosshair_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DIM_W-1:0] fw,
                                input logic [DIM_W-1:0] fh, input logic [23:0] rgb);
        while (!in_steady_window() && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_kind   <= kind;
        in_width  <= fw;
        in_height <= fh;
        in_red    <= rgb[23:16];
        in_green  <= rgb[15:8];
        in_blue   <= rgb[7:0];
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (kind != KIND_UNUSED)
            requests_sent++;
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n)
            send_request(KIND_TICK, DIM_W'($urandom), DIM_W'($urandom), 24'($urandom));
    endtask

    // A frame start followed by n pixels, with stray ticks and undefined
    // requests mixed in at the given percentage.
    task automatic send_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input int unsigned n, input int unsigned noise_pct);
        send_request(KIND_START, w, h, 24'($urandom));
        repeat (n) begin
            if ($urandom_range(99) < noise_pct)
                send_request($urandom_range(1) ? KIND_TICK : KIND_UNUSED,
                             DIM_W'($urandom), DIM_W'($urandom), 24'($urandom));
            send_request(KIND_PIXEL, DIM_W'($urandom), DIM_W'($urandom), 24'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        if (idx == CFG_FRAME_INTERVAL)
            interval_now = 32'(value);
    endtask

    // Registers only change once every result is out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        int unsigned phase_end;
        int unsigned phase_no;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: the interval has not elapsed, so the start is skipped.
        send_request(KIND_START, 12'd3, 12'd2, 24'($urandom));
        send_request(KIND_PIXEL, DIM_W'($urandom), DIM_W'($urandom), 24'($urandom));
        send_request(KIND_UNUSED, DIM_W'($urandom), DIM_W'($urandom), 24'($urandom));
        send_ticks(1);
        settle();

        // A 4x4 display puts every pixel of row 2 and column 2 on the crosshair.
        write_reg(CFG_DISPLAY_WIDTH, 24'd4);
        write_reg(CFG_DISPLAY_HEIGHT, 24'd4);
        write_reg(CFG_PITCH_BYTES, 24'd128);
        write_reg(CFG_FRAME_INTERVAL, 24'd2);
        send_request(KIND_START, 12'd2, 12'd2, 24'($urandom));
        send_ticks(1);
        send_frame(12'd0, 12'd5, 0, 0);
        send_ticks(2);
        send_frame(12'd4095, 12'd4095, 0, 0);
        send_request(KIND_PIXEL, 12'd4095, 12'd4095, 24'hFFFFFF);
        send_request(KIND_PIXEL, 12'd0, 12'd0, 24'h000000);
        // Abandons the huge frame; its last pixel falls right of the crop.
        send_ticks(2);
        send_frame(12'd5, 12'd1, 5, 0);
        // Last pixel sits on the horizontal arm and completes inside the crop.
        send_ticks(2);
        send_frame(12'd2, 12'd3, 6, 0);

        phase_no = 0;
        while (requests_sent < TOTAL_REQUESTS) begin
            settle();
            if (phase_no == 0) begin
                write_reg(CFG_DISPLAY_WIDTH, 24'd4095);
                write_reg(CFG_DISPLAY_HEIGHT, 24'd4095);
                write_reg(CFG_PITCH_BYTES, 24'd65535);
                write_reg(CFG_FRAME_INTERVAL, 24'd0);
            end else begin
                if ($urandom_range(99) < 60) begin
                    pick = $urandom_range(9);
                    write_reg(CFG_DISPLAY_WIDTH,
                              CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 4095
                                          : $urandom_range(2, 30)));
                end
                if ($urandom_range(99) < 60) begin
                    pick = $urandom_range(9);
                    write_reg(CFG_DISPLAY_HEIGHT,
                              CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 4095
                                          : $urandom_range(2, 16)));
                end
                if ($urandom_range(99) < 60) begin
                    pick = $urandom_range(9);
                    write_reg(CFG_PITCH_BYTES,
                              CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 65535
                                          : $urandom_range(65535)));
                end
                if ($urandom_range(99) < 60) begin
                    pick = $urandom_range(9);
                    write_reg(CFG_FRAME_INTERVAL,
                              CFG_DATA_W'((pick == 0) ? 24'hFFFFFF
                                          : (pick < 3) ? 0 : $urandom_range(1, 8)));
                end
            end
            phase_no++;

            phase_end = requests_sent + $urandom_range(100, 200);
            while (requests_sent < phase_end && requests_sent < TOTAL_REQUESTS) begin
                send_ticks((interval_now <= 8) ? $urandom_range(0, 2 * interval_now + 1)
                                               : $urandom_range(0, 3));
                pick = $urandom_range(99);
                if (pick < 6) begin
                    // A frame of up to 4095x4095, usually cut short; the next start abandons it.
                    w = $urandom_range(1) ? 4095 : $urandom_range(1, 4095);
                    h = $urandom_range(1) ? 4095 : $urandom_range(1, 4095);
                    send_frame(DIM_W'(w), DIM_W'(h), $urandom_range(0, 30), 4);
                end else if (pick < 16) begin
                    // Pixel counts from zero to three past the announced size, so often too few or too many.
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 6);
                    send_frame(DIM_W'(w), DIM_W'(h), $urandom_range(0, w * h + 3), 4);
                end else if (pick < 22) begin
                    repeat ($urandom_range(1, 4))
                        send_request(KIND_W'($urandom_range(3)), DIM_W'($urandom),
                                     DIM_W'($urandom), 24'($urandom));
                end else begin
                    w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
                    h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
                    send_frame(DIM_W'(w), DIM_W'(h), w * h, 4);
                end
            end
        end
        settle();

        if (mismatches == 0)
            $display("tb_rgb565_frame_writer_with_crosshair_top: clean");
        else
            $display("tb_rgb565_frame_writer_with_crosshair_top: errors");
        $finish;
    end

endmodule

>>> rgb565_frame_writer_with_crosshair_top.f
rtl/rfwc_pkg.sv
rtl/rfwc_pix_map.sv
rtl/rgb565_frame_writer_with_crosshair_top.sv
tb/rfwc_monitor.sv
tb/tb_rgb565_frame_writer_with_crosshair_top.sv
